// ===== sv/mecb_pkg.sv =====
// Package for the masked edge counter bank.
// Holds the beat structs, command and register codes, and shared constants.
// Used by every module of the block; depends on nothing.
package mecb_pkg;

    localparam int NUM_PINS     = 8;
    localparam int CHANNELS_DEF = 8;
    localparam int COUNT_W      = 8;
    localparam int CHAN_W       = 3;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RISING_MASK  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLING_MASK = 8'd1;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [NUM_PINS-1:0] pin_levels;
        logic [CHAN_W-1:0]   channel;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [NUM_PINS-1:0] edge_flags;
    } t_out_beat;

    typedef struct packed {
        logic sample;
        logic clear;
        logic level;
        logic rise_en;
        logic fall_en;
    } t_lane_ctl;

endpackage

// ===== sv/mecb_lane.sv =====
// One counter lane of the masked edge counter bank.
// Tracks its pin level, detects enabled edges and keeps an 8-bit count.
// Depends on mecb_pkg.
module mecb_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mecb_pkg::t_lane_ctl           i_ctl,
    output logic                          o_flag,
    output logic [mecb_pkg::COUNT_W-1:0]  o_count
);

    logic                          r_prev;
    logic [mecb_pkg::COUNT_W-1:0]  r_count;
    logic                          n_prev;
    logic [mecb_pkg::COUNT_W-1:0]  n_count;
    logic                          w_flag;

    always_comb begin
        w_flag = i_ctl.sample && (i_ctl.level != r_prev) &&
                 ((i_ctl.level && i_ctl.rise_en) || (!i_ctl.level && i_ctl.fall_en));
        n_prev = i_ctl.sample ? i_ctl.level : r_prev;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (w_flag) begin
            n_count = r_count + mecb_pkg::COUNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_count <= '0;
        end else begin
            r_prev  <= n_prev;
            r_count <= n_count;
        end
    end

    assign o_flag  = w_flag;
    assign o_count = r_count;

endmodule

// ===== sv/mecb_merge.sv =====
// Merge stage of the masked edge counter bank.
// Gathers lane flags into the edge flag word and selects the addressed count.
// Depends on mecb_pkg.
module mecb_merge #(
    parameter int LANES = mecb_pkg::CHANNELS_DEF
) (
    input  logic [mecb_pkg::CMD_W-1:0]               i_command,
    input  logic [mecb_pkg::CHAN_W-1:0]              i_channel,
    input  logic [LANES-1:0]                         i_flags,
    input  logic [LANES-1:0][mecb_pkg::COUNT_W-1:0]  i_counts,
    output mecb_pkg::t_out_beat                      o_result
);

    logic [mecb_pkg::COUNT_W-1:0]  w_sel;
    logic [mecb_pkg::NUM_PINS-1:0] w_flags;
    logic                          w_read;

    always_comb begin
        w_sel   = '0;
        w_flags = '0;
        for (int i = 0; i < LANES; i++) begin
            if (i_channel == mecb_pkg::CHAN_W'(i)) begin
                w_sel = i_counts[i];
            end
            w_flags[i] = i_flags[i];
        end
        w_read = (i_command == mecb_pkg::CMD_PEEK) || (i_command == mecb_pkg::CMD_GET);
        o_result.count      = w_read ? w_sel : '0;
        o_result.edge_flags = (i_command == mecb_pkg::CMD_SAMPLE) ? w_flags : '0;
    end

endmodule

// ===== sv/masked_edge_counter_bank_top.sv =====
// Top level of the masked edge counter bank: mask registers, lanes, output register.
// Instantiates mecb_lane and mecb_merge; depends on mecb_pkg.
//
// The block takes one command beat per clock and returns exactly one result beat
// for each from a single output register. All channel lanes update in parallel
// in the cycle a beat is accepted, so a following beat sees the new counts and
// levels at once. The input stalls only while a result waits in the output
// register and the output side stalls. Mask writes through the configuration
// port are always ready and should be made while the block is idle.
module masked_edge_counter_bank_top #(
    parameter int CHANNELS = mecb_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mecb_pkg::t_in_beat               i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mecb_pkg::t_out_beat              o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mecb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mecb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int LANES = (CHANNELS < mecb_pkg::NUM_PINS) ? CHANNELS : mecb_pkg::NUM_PINS;

    logic [mecb_pkg::NUM_PINS-1:0]           r_rise;
    logic [mecb_pkg::NUM_PINS-1:0]           r_fall;
    logic                                    r_out_valid;
    mecb_pkg::t_out_beat                     r_out;
    logic                                    w_in_acc;
    logic                                    w_cfg_acc;
    logic [LANES-1:0]                        w_flags;
    logic [LANES-1:0][mecb_pkg::COUNT_W-1:0] w_counts;
    mecb_pkg::t_out_beat                     w_result;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mecb_pkg::t_lane_ctl w_ctl;
        always_comb begin
            w_ctl.sample  = w_in_acc && (i_in.command == mecb_pkg::CMD_SAMPLE);
            w_ctl.clear   = w_in_acc && (i_in.command == mecb_pkg::CMD_GET) &&
                            (i_in.channel == mecb_pkg::CHAN_W'(g));
            w_ctl.level   = i_in.pin_levels[g];
            w_ctl.rise_en = r_rise[g];
            w_ctl.fall_en = r_fall[g];
        end
        mecb_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .o_flag  (w_flags[g]),
            .o_count (w_counts[g])
        );
    end

    mecb_merge #(.LANES(LANES)) u_merge (
        .i_command (i_in.command),
        .i_channel (i_in.channel),
        .i_flags   (w_flags),
        .i_counts  (w_counts),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise      <= '0;
            r_fall      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_acc && (i_cfg_index == mecb_pkg::REG_RISING_MASK)) begin
                r_rise <= i_cfg_data;
            end
            if (w_cfg_acc && (i_cfg_index == mecb_pkg::REG_FALLING_MASK)) begin
                r_fall <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_sample_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.command == mecb_pkg::CMD_SAMPLE)) |=> (r_out.count == '0))
        else $error("Sample result carries a nonzero count.");

    a_read_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.command != mecb_pkg::CMD_SAMPLE)) |=> (r_out.edge_flags == '0))
        else $error("Non-sample result carries edge flags.");

    a_flags_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> ((r_out.edge_flags & ~($past(r_rise) | $past(r_fall))) == '0))
        else $error("Edge flag set on a channel with both masks clear.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_out_valid)
        else $error("Accepted beat produced no pending result.");

endmodule

// ===== bench/tb_masked_edge_counter_bank_top.sv =====
// Self-checking testbench for masked_edge_counter_bank_top: directed table, random phases,
// output hold-off pressure and a wrap run, checked by table golds or a local edge predictor.
// Depends on mecb_pkg and the masked_edge_counter_bank_top RTL.
module tb_masked_edge_counter_bank_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mecb_pkg::CMD_W-1:0]     CMD_UNUSED     = 2'd3;
    localparam logic [mecb_pkg::CFG_IDX_W-1:0] REG_UNUSED     = 8'd2;
    localparam logic [mecb_pkg::CFG_IDX_W-1:0] REG_LAST_INDEX = 8'hFF;
    localparam int                             STUCK_LIMIT    = 2000;
    localparam int                             HOLD_CYCLES    = 300;
    localparam int                             PHASE_ITEMS    = 130;
    localparam int                             WRAP_SAMPLES   = 300;
    localparam int                             ENABLE_ROW     = 4;
    localparam int                             DIR_ROWS       = 18;

    typedef struct packed {
        logic [mecb_pkg::CMD_W-1:0]    command;
        logic [mecb_pkg::NUM_PINS-1:0] pins;
        logic [mecb_pkg::CHAN_W-1:0]   channel;
        logic                          has_gold;
        logic [mecb_pkg::COUNT_W-1:0]  gold_count;
        logic [mecb_pkg::NUM_PINS-1:0] gold_flags;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{mecb_pkg::CMD_PEEK,   8'h00, 3'd0, 1'b1, 8'd0, 8'h00},
        '{mecb_pkg::CMD_GET,    8'h00, 3'd7, 1'b1, 8'd0, 8'h00},
        '{mecb_pkg::CMD_SAMPLE, 8'hFF, 3'd0, 1'b1, 8'd0, 8'h00},
        '{CMD_UNUSED,           8'hFF, 3'd7, 1'b1, 8'd0, 8'h00},
        '{mecb_pkg::CMD_SAMPLE, 8'hFF, 3'd0, 1'b1, 8'd0, 8'h00},
        '{mecb_pkg::CMD_SAMPLE, 8'h00, 3'd0, 1'b1, 8'd0, 8'hFF},
        '{mecb_pkg::CMD_SAMPLE, 8'hFF, 3'd7, 1'b1, 8'd0, 8'hFF},
        '{mecb_pkg::CMD_PEEK,   8'h00, 3'd0, 1'b1, 8'd2, 8'h00},
        '{mecb_pkg::CMD_GET,    8'hFF, 3'd7, 1'b1, 8'd2, 8'h00},
        '{mecb_pkg::CMD_PEEK,   8'h00, 3'd7, 1'b1, 8'd0, 8'h00},
        '{CMD_UNUSED,           8'h00, 3'd0, 1'b1, 8'd0, 8'h00},
        '{mecb_pkg::CMD_SAMPLE, 8'hFF, 3'd0, 1'b1, 8'd0, 8'h00},
        '{mecb_pkg::CMD_SAMPLE, 8'hAA, 3'd0, 1'b1, 8'd0, 8'h55},
        '{mecb_pkg::CMD_SAMPLE, 8'h55, 3'd0, 1'b1, 8'd0, 8'hFF},
        '{mecb_pkg::CMD_PEEK,   8'h00, 3'd1, 1'b0, 8'd0, 8'h00},
        '{mecb_pkg::CMD_GET,    8'h00, 3'd0, 1'b0, 8'd0, 8'h00},
        '{mecb_pkg::CMD_GET,    8'hFF, 3'd0, 1'b1, 8'd0, 8'h00},
        '{mecb_pkg::CMD_SAMPLE, 8'h00, 3'd5, 1'b0, 8'd0, 8'h00}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    mecb_pkg::t_in_beat              i_in;
    logic                            o_out_valid;
    logic                            i_out_stall;
    mecb_pkg::t_out_beat             o_out;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [mecb_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mecb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    logic                            gold_valid;
    mecb_pkg::t_out_beat             gold_beat;

    logic [mecb_pkg::NUM_PINS-1:0]   rise_mask;
    logic [mecb_pkg::NUM_PINS-1:0]   fall_mask;
    logic [mecb_pkg::NUM_PINS-1:0]   last_levels;
    logic [mecb_pkg::COUNT_W-1:0]    edge_count [mecb_pkg::NUM_PINS];
    mecb_pkg::t_out_beat             results_due [$];

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;
    bit hold_req;
    int stuck_cycles;
    int errors;
    int results_checked;
    int wraps_seen;
    int cmd_seen [4];

    masked_edge_counter_bank_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic mecb_pkg::t_out_beat count_edges_step(input mecb_pkg::t_in_beat beat);
        mecb_pkg::t_out_beat           res;
        logic [mecb_pkg::NUM_PINS-1:0] changed;
        logic [mecb_pkg::NUM_PINS-1:0] armed;
        res = '0;
        case (beat.command)
            mecb_pkg::CMD_SAMPLE: begin
                changed = beat.pin_levels ^ last_levels;
                armed = (beat.pin_levels & rise_mask) | (~beat.pin_levels & fall_mask);
                res.edge_flags = changed & armed;
                last_levels = beat.pin_levels;
                for (int i = 0; i < mecb_pkg::NUM_PINS; i++) begin
                    if (res.edge_flags[i]) begin
                        if (edge_count[i] == 8'hFF) wraps_seen++;
                        edge_count[i] = edge_count[i] + 8'd1;
                    end
                end
            end
            mecb_pkg::CMD_PEEK: begin
                res.count = edge_count[beat.channel];
            end
            mecb_pkg::CMD_GET: begin
                res.count = edge_count[beat.channel];
                edge_count[beat.channel] = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic mecb_pkg::t_in_beat random_command();
        mecb_pkg::t_in_beat beat;
        int                 pick;
        pick = $urandom_range(0, 99);
        beat.pin_levels = mecb_pkg::NUM_PINS'($urandom_range(0, 255));
        beat.channel = mecb_pkg::CHAN_W'($urandom_range(0, 7));
        if (pick < 50) beat.command = mecb_pkg::CMD_SAMPLE;
        else if (pick < 70) beat.command = mecb_pkg::CMD_PEEK;
        else if (pick < 95) beat.command = mecb_pkg::CMD_GET;
        else beat.command = CMD_UNUSED;
        return beat;
    endfunction

    // Scoreboard: predicts on every accepted input beat, checks every accepted output beat.
    always @(posedge i_clk) begin
        mecb_pkg::t_out_beat pred;
        mecb_pkg::t_out_beat want;
        bit                  moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    mecb_pkg::REG_RISING_MASK:  rise_mask = i_cfg_data;
                    mecb_pkg::REG_FALLING_MASK: fall_mask = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results_checked++;
                if (results_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: count %0d flags %h",
                                 o_out.count, o_out.edge_flags);
                end else begin
                    want = results_due.pop_front();
                    if (o_out.count !== want.count ||
                        o_out.edge_flags !== want.edge_flags) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d: expected count %0d flags %h, %s %0d %s %h",
                                     results_checked, want.count, want.edge_flags,
                                     "got count", o_out.count, "flags", o_out.edge_flags);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                cmd_seen[i_in.command]++;
                pred = count_edges_step(i_in);
                results_due.push_back(gold_valid ? gold_beat : pred);
            end
        end
        stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("masked_edge_counter_bank_top: mismatch");
        $finish;
    end

    // Output side: random stall, or a long hold-off when one is requested.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
            end
        end
    end

    task automatic offer_beat(input mecb_pkg::t_in_beat beat, input logic has_gold,
                              input mecb_pkg::t_out_beat gold);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= beat;
        gold_valid <= has_gold;
        gold_beat <= gold;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic offer_random(input mecb_pkg::t_in_beat beat);
        offer_beat(beat, 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_mask_reg(input logic [mecb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mecb_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        mecb_pkg::t_in_beat  beat;
        mecb_pkg::t_out_beat gold;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        gold_valid = 1'b0;
        gold_beat = '0;
        rise_mask = '0;
        fall_mask = '0;
        last_levels = '0;
        for (int i = 0; i < mecb_pkg::NUM_PINS; i++) edge_count[i] = '0;
        for (int i = 0; i < 4; i++) cmd_seen[i] = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 0;
        hold_req = 1'b0;
        stuck_cycles = 0;
        errors = 0;
        results_checked = 0;
        wraps_seen = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (r == ENABLE_ROW) begin
                wait_drained();
                write_mask_reg(mecb_pkg::REG_RISING_MASK, 8'hFF);
                write_mask_reg(mecb_pkg::REG_FALLING_MASK, 8'hFF);
                write_mask_reg(REG_UNUSED, 8'h00);
            end
            beat.command = DIR_TABLE[r].command;
            beat.pin_levels = DIR_TABLE[r].pins;
            beat.channel = DIR_TABLE[r].channel;
            gold.count = DIR_TABLE[r].gold_count;
            gold.edge_flags = DIR_TABLE[r].gold_flags;
            offer_beat(beat, DIR_TABLE[r].has_gold, gold);
        end

        for (int p = 0; p < 4; p++) begin
            wait_drained();
            case (p)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    write_mask_reg(mecb_pkg::REG_RISING_MASK, 8'hFF);
                    write_mask_reg(mecb_pkg::REG_FALLING_MASK, 8'h00);
                end
                1: begin
                    src_idle_pct = 70;
                    sink_stall_pct = 0;
                    write_mask_reg(mecb_pkg::REG_RISING_MASK, 8'h00);
                    write_mask_reg(mecb_pkg::REG_FALLING_MASK, 8'hFF);
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 70;
                    write_mask_reg(mecb_pkg::REG_RISING_MASK,
                                   mecb_pkg::CFG_DATA_W'($urandom_range(0, 255)));
                    write_mask_reg(mecb_pkg::REG_FALLING_MASK,
                                   mecb_pkg::CFG_DATA_W'($urandom_range(0, 255)));
                end
                default: begin
                    src_idle_pct = 35;
                    sink_stall_pct = 35;
                    write_mask_reg(mecb_pkg::REG_FALLING_MASK,
                                   mecb_pkg::CFG_DATA_W'($urandom_range(0, 255)));
                    write_mask_reg(mecb_pkg::REG_RISING_MASK,
                                   mecb_pkg::CFG_DATA_W'($urandom_range(0, 255)));
                    write_mask_reg(REG_LAST_INDEX, 8'hFF);
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) offer_random(random_command());
        end

        // Toggle every pin long enough that each counter passes 255, then read all back.
        wait_drained();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        write_mask_reg(mecb_pkg::REG_RISING_MASK, 8'hFF);
        write_mask_reg(mecb_pkg::REG_FALLING_MASK, 8'hFF);
        for (int k = 0; k < WRAP_SAMPLES; k++) begin
            beat.command = mecb_pkg::CMD_SAMPLE;
            beat.pin_levels = k[0] ? 8'hFF : 8'h00;
            beat.channel = mecb_pkg::CHAN_W'($urandom_range(0, 7));
            offer_random(beat);
        end
        for (int ch = 0; ch < mecb_pkg::NUM_PINS; ch++) begin
            beat.pin_levels = mecb_pkg::NUM_PINS'($urandom_range(0, 255));
            beat.channel = mecb_pkg::CHAN_W'(ch);
            beat.command = mecb_pkg::CMD_PEEK;
            offer_random(beat);
            beat.command = mecb_pkg::CMD_GET;
            offer_random(beat);
        end

        // Hold the output off while beats keep coming, so the input has to stall.
        wait_drained();
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++) offer_random(random_command());
        wait_drained();

        repeat (5) @(posedge i_clk);
        errors += results_due.size();
        $display("Checked %0d result beats: %0d samples, %0d peeks, %0d gets, %0d %s",
                 results_checked, cmd_seen[mecb_pkg::CMD_SAMPLE],
                 cmd_seen[mecb_pkg::CMD_PEEK], cmd_seen[mecb_pkg::CMD_GET],
                 cmd_seen[CMD_UNUSED], "unknown commands.");
        $display("Mask settings included all-on, rising-only, falling-only and random; %0d %s",
                 wraps_seen, "counter wraps.");
        if (errors == 0) begin
            $display("masked_edge_counter_bank_top: match");
        end else begin
            $display("masked_edge_counter_bank_top: mismatch");
        end
        $finish;
    end

endmodule
